// ===== rtl/bds_pkg.sv =====
// Package for the baud divisor search block: widths, constants and the
// structs passed between the sequencer, the divider and the top level.
// No dependencies.
package bds_pkg;

    localparam int unsigned DIV_W      = 32;
    localparam int unsigned CNT_W      = $clog2(DIV_W);
    localparam int unsigned EXPO_W     = 4;
    localparam int unsigned TC_W       = 9;
    localparam int unsigned TC_REG_W   = 8;

    localparam logic [DIV_W-1:0]  SRC_FREQ_RESET   = 32'd9830400;
    localparam logic [EXPO_W-1:0] EXPO_START       = 4'd9;
    localparam logic [EXPO_W-1:0] EXPO_MIN         = 4'd1;
    localparam logic [EXPO_W-1:0] EXPO_ZERO        = 4'd0;
    localparam logic [TC_W-1:0]   TC_SAT           = 9'd256;
    localparam logic [TC_W-1:0]   TC_ONE           = 9'd1;
    localparam logic [DIV_W-1:0]  TC_STEP_LIMIT    = 32'd128;
    localparam logic [DIV_W-1:0]  TC_MAX_REG       = 32'd255;
    // zero request: source frequency / (256 * 512)
    localparam int unsigned       ZERO_RATE_SHIFT  = 17;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic              busy;
        logic              res_valid;
    } t_seq_stat;

    typedef struct packed {
        logic [EXPO_W-1:0] expo;
        logic [TC_W-1:0]   tc;
        logic [DIV_W-1:0]  achieved;
    } t_result;

endpackage

// ===== rtl/baud_divisor_search.sv =====
// Baud divisor search. A zero rate needs no division: the sequencer goes
// straight to its push state. Any other request runs one division per
// prescaler exponent tried, from 9 down as far as 1, plus one more for the
// achieved rate unless nothing fits. Each division runs on the single shared
// bit-serial divider (issue, 32 steps, done); a finished result waits in the
// push state while the output register is still held. The request side
// stalls while a search runs; the result sits in an output register so a new
// request is taken while it waits to be read. The source frequency is written
// through the config port, which is ready only while no search runs.
// Depends on bds_pkg, bds_seq and bds_div.
module baud_divisor_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  logic [31:0] i_requested_rate,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [3:0]  o_prescale_exponent,
    output logic [8:0]  o_time_constant,
    output logic [7:0]  o_time_constant_reg,
    output logic [31:0] o_achieved_rate
);
    import bds_pkg::*;

    logic [DIV_W-1:0]  r_src_freq;
    logic              r_res_valid;
    logic [EXPO_W-1:0] r_expo;
    logic [TC_W-1:0]   r_tc;
    logic [DIV_W-1:0]  r_ach;

    t_seq_stat stat;
    t_result   res;
    t_div_cmd  cmd;
    t_div_rsp  rsp;
    logic      start;
    logic      out_free;
    logic      load;

    assign o_cfg_ready = ~stat.busy;
    assign start       = i_req_valid & ~stat.busy;
    assign out_free    = ~r_res_valid | ~i_res_stall;
    assign load        = stat.res_valid & out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_freq  <= SRC_FREQ_RESET;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_src_freq <= i_cfg_data;
            end
            if (load) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_expo <= res.expo;
            r_tc   <= res.tc;
            r_ach  <= res.achieved;
        end
    end

    bds_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_rate       (i_requested_rate),
        .i_src_freq   (r_src_freq),
        .i_out_free   (out_free),
        .o_stat       (stat),
        .o_res        (res),
        .o_cmd        (cmd),
        .i_rsp        (rsp)
    );

    bds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    assign o_req_stall         = stat.busy;
    assign o_res_valid         = r_res_valid;
    assign o_prescale_exponent = r_expo;
    assign o_time_constant     = r_tc;
    assign o_time_constant_reg = r_tc[TC_REG_W-1:0];
    assign o_achieved_rate     = r_ach;

endmodule

// ===== rtl/bds_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on bds_pkg. Divisor must be nonzero.
module bds_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bds_pkg::t_div_cmd  i_cmd,
    output bds_pkg::t_div_rsp  o_rsp
);
    import bds_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;
    logic             ge;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        ge      = ~diff[DIV_W+1];
        n_rem   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        n_quo   = {r_quo[DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_quo <= i_cmd.dividend;
            r_dvs <= i_cmd.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/bds_seq.sv =====
// Search sequencer: walks the prescaler exponent down, issuing divisions to
// the shared divider, then computes the achieved rate. Depends on bds_pkg.
module bds_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [31:0]             i_rate,
    input  logic [31:0]             i_src_freq,
    input  logic                    i_out_free,
    output bds_pkg::t_seq_stat      o_stat,
    output bds_pkg::t_result        o_res,
    output bds_pkg::t_div_cmd       o_cmd,
    input  bds_pkg::t_div_rsp       i_rsp
);
    import bds_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_TC,
        S_DIV_ACH,
        S_PUSH
    } t_state;

    t_state            r_state;
    t_div_cmd          r_cmd;
    logic [EXPO_W-1:0] r_expo;
    logic [TC_W-1:0]   r_tc;
    logic [DIV_W-1:0]  r_ach;
    logic [DIV_W-1:0]  r_rate;
    logic [DIV_W-1:0]  r_base_sh;

    logic [DIV_W-1:0]  quo;
    logic [TC_W-1:0]   n_tc;
    logic [DIV_W-1:0]  base_dn;

    always_comb begin
        quo     = i_rsp.quotient;
        n_tc    = (quo > TC_MAX_REG) ? TC_SAT : quo[TC_W-1:0];
        // source frequency scaled for the next lower exponent
        base_dn = i_src_freq >> (r_expo - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd.start <= 1'b0;
        end else begin
            r_cmd.start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rate <= i_rate;
                        r_expo <= EXPO_START;
                        if (i_rate == '0) begin
                            r_tc    <= TC_SAT;
                            r_ach   <= i_src_freq >> ZERO_RATE_SHIFT;
                            r_state <= S_PUSH;
                        end else begin
                            r_base_sh      <= i_src_freq >> EXPO_START;
                            r_cmd.start    <= 1'b1;
                            r_cmd.dividend <= i_src_freq >> EXPO_START;
                            r_cmd.divisor  <= i_rate;
                            r_state        <= S_DIV_TC;
                        end
                    end
                end
                S_DIV_TC: begin
                    if (i_rsp.done) begin
                        if (r_expo > EXPO_MIN && quo <= TC_STEP_LIMIT) begin
                            r_expo         <= r_expo - 1'b1;
                            r_base_sh      <= base_dn;
                            r_cmd.start    <= 1'b1;
                            r_cmd.dividend <= base_dn;
                            r_cmd.divisor  <= r_rate;
                        end else if (quo == '0) begin
                            // nothing fits: run the generator undivided
                            r_expo  <= EXPO_ZERO;
                            r_tc    <= TC_ONE;
                            r_ach   <= i_src_freq;
                            r_state <= S_PUSH;
                        end else begin
                            r_tc           <= n_tc;
                            r_cmd.start    <= 1'b1;
                            r_cmd.dividend <= r_base_sh;
                            r_cmd.divisor  <= {{(DIV_W-TC_W){1'b0}}, n_tc};
                            r_state        <= S_DIV_ACH;
                        end
                    end
                end
                S_DIV_ACH: begin
                    if (i_rsp.done) begin
                        r_ach   <= quo;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.res_valid = (r_state == S_PUSH);
    assign o_res.expo       = r_expo;
    assign o_res.tc         = r_tc;
    assign o_res.achieved   = r_ach;
    assign o_cmd            = r_cmd;

endmodule

// ===== rtl/bds_checker.sv =====
// Port-level checks for baud_divisor_search, attached by bind.
// Depends only on the top level's ports.
module bds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_req_valid,
    input logic        o_req_stall,
    input logic        o_res_valid,
    input logic        i_res_stall,
    input logic [3:0]  o_prescale_exponent,
    input logic [8:0]  o_time_constant,
    input logic [7:0]  o_time_constant_reg,
    input logic [31:0] o_achieved_rate
);

    // a stalled result beat stays put
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=>
            (o_res_valid && $stable(o_time_constant) && $stable(o_achieved_rate)
             && $stable(o_prescale_exponent)))
        else $error("result beat changed while stalled");

    // a search always occupies the block past the accepting edge
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_req_stall)
        else $error("request side not stalled after accepting a beat");

    a_tc_encoding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_time_constant_reg == o_time_constant[7:0]
                         && o_time_constant != 9'd0 && o_time_constant <= 9'd256
                         && o_prescale_exponent <= 4'd9))
        else $error("time constant or exponent out of range");

    // exponent zero only comes from the undivided fallback
    a_expo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_prescale_exponent == 4'd0) |-> (o_time_constant == 9'd1))
        else $error("exponent zero without time constant one");

    // config beats only land while no search runs
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !o_req_stall)
        else $error("config beat taken during a search");

endmodule

bind baud_divisor_search bds_checker u_bds_checker (.*);
